FILE: design/radial_smoothstep_macros.svh
// Assertion macros shared by the radial smoothstep RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef RADIAL_SMOOTHSTEP_MACROS_SVH
`define RADIAL_SMOOTHSTEP_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RSMST_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger at one edge implies condition at the next edge.
`define RSMST_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: design/rsmst_pkg.sv
// Package for the radial smoothstep block: widths, codes, item type, coefficients.
// No dependencies.
package rsmst_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int POLY_TERMS_DEF = 6;

  localparam int COORD_W   = 24;
  localparam int LEN_W     = 23;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_W      = 2 * COORD_W + 1;
  localparam int ROOT_W    = COORD_W + 1;
  localparam int DIST_W    = LEN_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [LEN_W-1:0] BAND_RESET = LEN_W'(65536);

  typedef enum logic [1:0] {
    CLS_INSIDE  = 2'd0,
    CLS_BAND    = 2'd1,
    CLS_OUTSIDE = 2'd2
  } rsmst_cls_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_INNER_RADIUS = 2'd2,
    REG_BAND_WIDTH   = 2'd3
  } rsmst_reg_t;

  typedef struct packed {
    rsmst_cls_t         cls;
    logic [DIST_W-1:0]  span;
  } rsmst_item_t;

  function automatic int poly_coef(input int i);
    int c;
    case (i)
      0:       c = 6;
      1:       c = -15;
      2:       c = 10;
      default: c = 0;
    endcase
    return c;
  endfunction

endpackage

FILE: design/rsmst_front.sv
// Front end: center offset, squares, pipelined square root, classification.
// Depends on rsmst_pkg.
module rsmst_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rsmst_pkg::COORD_W-1:0]        in_point_x,
  input  logic [rsmst_pkg::COORD_W-1:0]        in_point_y,
  input  logic [rsmst_pkg::COORD_W-1:0]        center_x,
  input  logic [rsmst_pkg::COORD_W-1:0]        center_y,
  input  logic [rsmst_pkg::LEN_W-1:0]          inner_radius,
  input  logic [rsmst_pkg::LEN_W-1:0]          band_len,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output rsmst_pkg::rsmst_item_t               push_item
);
  import rsmst_pkg::*;

  localparam int NS = ROOT_W + 4;

  logic [NS-1:0] vld_r;
  logic          adv;

  assign adv      = !vld_r[NS-1] || push_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // offset and magnitude
  logic [COORD_W:0]   dx, dy, ndx, ndy;
  logic [COORD_W-1:0] adx_r, ady_r;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;
  logic [SQ_W-1:0]    n_r;

  assign dx  = {in_point_x[COORD_W-1], in_point_x} - {center_x[COORD_W-1], center_x};
  assign dy  = {in_point_y[COORD_W-1], in_point_y} - {center_y[COORD_W-1], center_y};
  assign ndx = ~dx + (COORD_W+1)'(1);
  assign ndy = ~dy + (COORD_W+1)'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      adx_r <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
      ady_r <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
      n_r   <= SQ_W'(sqx_r) + SQ_W'(sqy_r);
    end
  end

  // square root, one result bit per stage
  logic [SQ_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W+1:0]   cand;

    if (k == 0) begin : g_first
      assign rem_in  = n_r;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cand = ((SQ_W+2)'(root_in) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (adv) begin
        if ((SQ_W+2)'(rem_in) >= cand) begin
          rem_r[k]  <= rem_in - cand[SQ_W-1:0];
          root_r[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  // classify against the band
  logic [ROOT_W-1:0] r, ir, hi, d;
  rsmst_item_t       item_r;

  assign r  = root_r[ROOT_W-1];
  assign ir = ROOT_W'(inner_radius);
  assign hi = ROOT_W'(inner_radius) + ROOT_W'(band_len);
  assign d  = r - ir;

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r.span <= d[DIST_W-1:0];
      if (r < ir) begin
        item_r.cls <= CLS_INSIDE;
      end else if (r > hi) begin
        item_r.cls <= CLS_OUTSIDE;
      end else begin
        item_r.cls <= CLS_BAND;
      end
    end
  end

  assign push_valid = vld_r[NS-1];
  assign push_item  = item_r;

endmodule

FILE: design/rsmst_fifo.sv
// Short queue of classified words between front and back end.
// Depends on rsmst_pkg and radial_smoothstep_macros.svh.
`include "radial_smoothstep_macros.svh"
module rsmst_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  rsmst_pkg::rsmst_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output rsmst_pkg::rsmst_item_t pop_item
);
  import rsmst_pkg::*;

  rsmst_item_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push, pop;

  assign push_ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  `RSMST_ASSERT_ALWAYS(a_ptr_cnt, QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0], "queue pointers disagree with count")
  `RSMST_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + QCNT_W'(1), "queue count missed a push")
  `RSMST_ASSERT_NEXT(a_cnt_dn, pop && !push, cnt_r == $past(cnt_r) - QCNT_W'(1), "queue count missed a pop")

endmodule

FILE: design/rsmst_back.sv
// Back end: pipelined band division, Horner stages, clamp and output register.
// Depends on rsmst_pkg and radial_smoothstep_macros.svh.
`include "radial_smoothstep_macros.svh"
module rsmst_back #(
  parameter int FRAC_BITS  = rsmst_pkg::FRAC_BITS_DEF,
  parameter int POLY_TERMS = rsmst_pkg::POLY_TERMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  rsmst_pkg::rsmst_item_t      pop_item,
  input  logic [rsmst_pkg::LEN_W-1:0] band_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [FRAC_BITS:0]          out_step_value
);
  import rsmst_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NH    = POLY_TERMS - 1;
  localparam int NS    = QW + NH + 1;
  localparam int ACC_W = FRAC_BITS + 6;
  localparam int PW    = ACC_W + QW + 1;
  localparam logic [QW-1:0]           ONE_Q   = QW'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] C0      = ACC_W'(poly_coef(0)) <<< FRAC_BITS;

  logic [NS-1:0] vld_r;
  logic          adv;

  assign adv       = !vld_r[NS-1] || out_ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], pop_valid};
    end
  end

  rsmst_cls_t        cls_r [NS-1];
  logic [DIST_W-1:0] rem_r [QW];
  logic [QW-1:0]     q_r   [QW];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DIST_W:0]   t, t_sub;
    logic [QW-1:0]     q_in;
    rsmst_cls_t        cls_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign t      = (DIST_W+1)'(pop_item.span);
      assign q_in   = '0;
      assign cls_in = pop_item.cls;
    end else begin : g_next
      assign t      = {rem_r[j-1], 1'b0};
      assign q_in   = q_r[j-1];
      assign cls_in = cls_r[j-1];
    end

    assign ge    = t >= (DIST_W+1)'(band_len);
    assign t_sub = t - (DIST_W+1)'(band_len);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j] <= ge ? t_sub[DIST_W-1:0] : t[DIST_W-1:0];
        q_r[j]   <= {q_in[QW-2:0], ge};
        cls_r[j] <= cls_in;
      end
    end
  end

  logic [QW-1:0] xq, xc;
  assign xq = q_r[QW-1];
  assign xc = (xq > ONE_Q) ? ONE_Q : xq;

  logic signed [ACC_W-1:0] acc_r [NH];
  logic [QW-1:0]           x_r   [NH];

  // Horner steps: acc = floor(acc * x / one) + c
  for (genvar h = 0; h < NH; h++) begin : g_horner
    localparam logic signed [ACC_W-1:0] CH = ACC_W'(poly_coef(h + 1)) <<< FRAC_BITS;
    logic signed [ACC_W-1:0] acc_in;
    logic [QW-1:0]           x_in;
    logic signed [PW-1:0]    prod, prod_sh;

    if (h == 0) begin : g_first
      assign acc_in = C0;
      assign x_in   = xc;
    end else begin : g_next
      assign acc_in = acc_r[h-1];
      assign x_in   = x_r[h-1];
    end

    assign prod    = acc_in * $signed({1'b0, x_in});
    assign prod_sh = prod >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r[h]      <= prod_sh[ACC_W-1:0] + CH;
        x_r[h]        <= x_in;
        cls_r[QW + h] <= cls_r[QW + h - 1];
      end
    end
  end

  logic signed [ACC_W-1:0] acc_last;
  logic [QW-1:0]           out_step_r;
  assign acc_last = acc_r[NH-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      case (cls_r[NS-2])
        CLS_INSIDE:  out_step_r <= '0;
        CLS_OUTSIDE: out_step_r <= ONE_Q;
        default: begin
          if (acc_last < 0) begin
            out_step_r <= '0;
          end else if (acc_last > ONE_ACC) begin
            out_step_r <= ONE_Q;
          end else begin
            out_step_r <= acc_last[QW-1:0];
          end
        end
      endcase
    end
  end

  assign out_valid      = vld_r[NS-1];
  assign out_step_value = out_step_r;

  `RSMST_ASSERT_ALWAYS(a_out_le_one, !out_valid || out_step_value <= ONE_Q, "step value above one")

endmodule

FILE: design/radial_smoothstep.sv
// Top level of the radial smoothstep block: configuration registers and the
// front end, queue and back end. Depends on rsmst_pkg and the rsmst_* modules.
//
// Usage:
//   Input channel (in_valid/in_ready, in_point_x, in_point_y): one 2-D point per
//   word, signed Q7.16. Result channel (out_valid/out_ready, out_step_value):
//   one word per point, unsigned Q1.16, 0 inside the inner radius, one beyond
//   the band, the quintic smoothstep of the scaled distance in between.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
//   center x, 1 center y, 2 inner radius, 3 band width; write only while idle.
//   A band width of zero is stored as one LSB.
// Pipeline: the front end (offset, squares, a 25-stage square root, classify),
//   the queue, then FRAC_BITS+1 divider stages, POLY_TERMS-1 Horner stages
//   and the output register.
// Throughput: one point per cycle unless stalled; arithmetic is fully pipelined.
// Reset: synchronous, clears all valid bits and the queue and loads the register
//   reset values (center 0, inner radius 0, band width one).
// Stall: when out_ready is low the back end holds; the four-word queue keeps the
//   front end moving until it fills, after which in_ready drops.
module radial_smoothstep #(
  parameter int FRAC_BITS  = rsmst_pkg::FRAC_BITS_DEF,
  parameter int POLY_TERMS = rsmst_pkg::POLY_TERMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rsmst_pkg::COORD_W-1:0]   in_point_x,
  input  logic [rsmst_pkg::COORD_W-1:0]   in_point_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [FRAC_BITS:0]              out_step_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsmst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsmst_pkg::COORD_W-1:0]   cfg_data
);
  import rsmst_pkg::*;

  logic [COORD_W-1:0] center_x_r, center_y_r;
  logic [LEN_W-1:0]   inner_radius_r, band_len_r;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      inner_radius_r <= '0;
      band_len_r     <= BAND_RESET;
    end else if (cfg_valid) begin
      unique case (rsmst_reg_t'(cfg_index))
        REG_CENTER_X:     center_x_r     <= cfg_data;
        REG_CENTER_Y:     center_y_r     <= cfg_data;
        REG_INNER_RADIUS: inner_radius_r <= cfg_data[LEN_W-1:0];
        REG_BAND_WIDTH: begin
          // treat a zero band as one LSB
          band_len_r <= (cfg_data[LEN_W-1:0] == '0) ? LEN_W'(1) : cfg_data[LEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  logic        push_valid, push_ready, pop_valid, pop_ready;
  rsmst_item_t push_item, pop_item;

  rsmst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .center_x     (center_x_r),
    .center_y     (center_y_r),
    .inner_radius (inner_radius_r),
    .band_len     (band_len_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  rsmst_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  rsmst_back #(
    .FRAC_BITS  (FRAC_BITS),
    .POLY_TERMS (POLY_TERMS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .band_len       (band_len_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step_value (out_step_value)
  );

endmodule
